/* rtl/spn_pkg.sv */
package spn_pkg;

  localparam int unsigned BlockW = 32;
  localparam int unsigned AddrW  = 4;

  typedef logic [7:0] sbox_t [256];

  typedef enum logic [1:0] {
    MODE_ECB = 2'd0,
    MODE_CBC = 2'd1,
    MODE_OFB = 2'd2
  } mode_e;

  localparam logic [1:0] REG_KEY  = 2'd0;
  localparam logic [1:0] REG_IV   = 2'd1;
  localparam logic [1:0] REG_MODE = 2'd2;
  localparam logic [1:0] REG_DIR  = 2'd3;

  localparam logic DIR_ENC = 1'b0;

  typedef struct packed {
    logic [BlockW-1:0] k0;
    logic [BlockW-1:0] k1;
    logic [BlockW-1:0] k2;
    logic [BlockW-1:0] iv;
    logic [1:0]        mode;
    logic              dir;
  } cfg_t;

  localparam sbox_t SBOX_FWD = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic sbox_t inv_table();
    sbox_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = 8'h00;
    end
    for (int i = 0; i < 256; i++) begin
      t[SBOX_FWD[i]] = 8'(i);
    end
    return t;
  endfunction

  localparam sbox_t SBOX_INV = inv_table();

endpackage

/* rtl/toy_spn_cipher_ecb_cbc_ofb.sv */
// A transaction passes the input register and then the result register on its way to the result.
// Throughput: one block per cycle while out_ready_i is not held low; both rounds and the chain
// update are combinational between the input register and the result register, so chaining never stalls.
// Reset: rst_ni is asynchronous, active low; clears the configuration registers, round
// keys and the chain value to zero and empties both stages.
module toy_spn_cipher_ecb_cbc_ofb import spn_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrW-1:0]     paddr,
  input  logic [BlockW-1:0]    pwdata,
  output logic [BlockW-1:0]    prdata,
  output logic                 pready,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [BlockW-1:0]    data_in_i,
  input  logic                 first_block_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [BlockW-1:0]    data_out_o
);

  cfg_t              cfg;
  logic              in_valid_q, in_first_q, out_valid_q;
  logic [BlockW-1:0] in_data_q, out_data_q, chain_q;
  logic [BlockW-1:0] result, chain_d;
  logic              advance, in_take;

  spn_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  spn_core u_core (
    .cfg_i    (cfg),
    .data_i   (in_data_q),
    .first_i  (in_first_q),
    .chain_i  (chain_q),
    .result_o (result),
    .chain_o  (chain_d)
  );

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      chain_q     <= '0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
        if (in_valid_q) begin
          chain_q <= chain_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_data_q  <= data_in_i;
      in_first_q <= first_block_i;
    end
    if (advance && in_valid_q) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign data_out_o  = out_data_q;

  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && advance) |=> out_valid_q)
    else $error("transaction lost between stages");

  a_chain_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> $stable(chain_q))
    else $error("chain changed while result stalled");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_valid_q && out_valid_q))
    else $error("input stalled with a free stage");

  a_enc_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && advance && cfg.mode != MODE_OFB && cfg.dir == DIR_ENC)
    |=> (chain_q == out_data_q))
    else $error("encrypt chain does not match result");

endmodule

/* rtl/spn_regs.sv */
module spn_regs import spn_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrW-1:0]     paddr,
  input  logic [BlockW-1:0]    pwdata,
  output logic [BlockW-1:0]    prdata,
  output logic                 pready,
  output cfg_t                 cfg_o
);

  logic [BlockW-1:0] key_q, k1_q, k2_q, iv_q;
  logic [1:0]        mode_q;
  logic              dir_q;
  logic              wr_en;
  logic [1:0]        reg_idx;
  logic [BlockW-1:0] k1_d;

  // reverse the key over its bits up to and including the highest set bit
  function automatic logic [BlockW-1:0] rev_sig(input logic [BlockW-1:0] k);
    logic [BlockW-1:0] r;
    logic [4:0]        lz;
    lz = 5'd0;
    for (int i = 0; i < BlockW; i++) begin
      r[i] = k[BlockW-1-i];
      if (k[i]) begin
        lz = 5'(BlockW - 1 - i);
      end
    end
    return r >> lz;
  endfunction

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[AddrW-1:2];
  assign k1_d    = rev_sig(pwdata);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q  <= '0;
      k1_q   <= '0;
      k2_q   <= '0;
      iv_q   <= '0;
      mode_q <= MODE_ECB;
      dir_q  <= DIR_ENC;
    end else if (wr_en) begin
      case (reg_idx)
        REG_KEY: begin
          key_q <= pwdata;
          k1_q  <= k1_d;
          k2_q  <= pwdata ^ k1_d;
        end
        REG_IV:   iv_q   <= pwdata;
        REG_MODE: mode_q <= pwdata[1:0];
        REG_DIR:  dir_q  <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_KEY:  prdata = key_q;
      REG_IV:   prdata = iv_q;
      REG_MODE: prdata = {30'd0, mode_q};
      REG_DIR:  prdata = {31'd0, dir_q};
      default:  prdata = '0;
    endcase
  end

  assign cfg_o = '{k0: key_q, k1: k1_q, k2: k2_q, iv: iv_q, mode: mode_q, dir: dir_q};

endmodule

/* rtl/spn_core.sv */
module spn_core import spn_pkg::*; (
  input  cfg_t              cfg_i,
  input  logic [BlockW-1:0] data_i,
  input  logic              first_i,
  input  logic [BlockW-1:0] chain_i,
  output logic [BlockW-1:0] result_o,
  output logic [BlockW-1:0] chain_o
);

  function automatic logic [31:0] sub_fwd(input logic [31:0] x);
    logic [31:0] r;
    for (int b = 0; b < 4; b++) begin
      r[8*b +: 8] = SBOX_FWD[x[8*b +: 8]];
    end
    return r;
  endfunction

  function automatic logic [31:0] sub_inv(input logic [31:0] x);
    logic [31:0] r;
    for (int b = 0; b < 4; b++) begin
      r[8*b +: 8] = SBOX_INV[x[8*b +: 8]];
    end
    return r;
  endfunction

  function automatic logic [31:0] swap_low(input logic [31:0] x);
    return {x[31:16], x[7:0], x[15:8]};
  endfunction

  logic [BlockW-1:0] c, fwd_in, e, d;
  logic              is_ofb, is_cbc;

  assign is_ofb = (cfg_i.mode == MODE_OFB);
  assign is_cbc = (cfg_i.mode == MODE_CBC);
  assign c      = first_i ? cfg_i.iv : chain_i;
  assign fwd_in = is_ofb ? c : (is_cbc ? (data_i ^ c) : data_i);
  assign e      = swap_low(sub_fwd(swap_low(sub_fwd(fwd_in ^ cfg_i.k0)) ^ cfg_i.k1))
                  ^ cfg_i.k2;
  assign d      = sub_inv(swap_low(sub_inv(swap_low(data_i ^ cfg_i.k2)) ^ cfg_i.k1))
                  ^ cfg_i.k0;

  always_comb begin
    if (is_ofb) begin
      chain_o  = e;
      result_o = e ^ data_i;
    end else if (cfg_i.dir == DIR_ENC) begin
      chain_o  = e;
      result_o = e;
    end else begin
      chain_o  = data_i;
      result_o = is_cbc ? (d ^ c) : d;
    end
  end

endmodule

/* tb/toy_spn_cipher_ecb_cbc_ofb_tb.sv */
module toy_spn_cipher_ecb_cbc_ofb_tb;
  import spn_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_RSVD = 2'd3;
  localparam logic       DIR_DEC = !DIR_ENC;
  localparam int         DRAIN_CYCLES = 8;
  localparam int         STALL_LIMIT = 5000;

  localparam logic [7:0] SUBST [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AddrW-1:0]  paddr;
  logic [BlockW-1:0] pwdata;
  logic [BlockW-1:0] prdata;
  logic              pready;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [BlockW-1:0] data_in_i;
  logic              first_block_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [BlockW-1:0] data_out_o;

  logic [7:0]        unsubst [256];
  logic [31:0]       cfg_key;
  logic [31:0]       cfg_iv;
  logic [1:0]        cfg_mode;
  logic              cfg_dir;
  logic [31:0]       chain_reg;
  logic [31:0]       blocks_due [$];
  int                bad_blocks;
  int                idle_cycles;
  bit                quiet;

  toy_spn_cipher_ecb_cbc_ofb i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_in_i     (data_in_i),
    .first_block_i (first_block_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .data_out_o    (data_out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [31:0] subst_word(input logic [31:0] x, input bit inv);
    logic [31:0] r;
    for (int i = 0; i < 4; i++) begin
      r[8*i +: 8] = inv ? unsubst[x[8*i +: 8]] : SUBST[x[8*i +: 8]];
    end
    return r;
  endfunction

  function automatic logic [31:0] swap_low_bytes(input logic [31:0] x);
    return {x[31:16], x[7:0], x[15:8]};
  endfunction

  function automatic logic [31:0] mirror_key(input logic [31:0] k);
    logic [31:0] r;
    logic [31:0] rest;
    r = '0;
    rest = k;
    while (rest != 0) begin
      r = {r[30:0], rest[0]};
      rest = rest >> 1;
    end
    return r;
  endfunction

  function automatic logic [31:0] encrypt_block(input logic [31:0] x);
    logic [31:0] k1;
    logic [31:0] k2;
    k1 = mirror_key(cfg_key);
    k2 = cfg_key ^ k1;
    x = x ^ cfg_key;
    x = swap_low_bytes(subst_word(x, 1'b0)) ^ k1;
    x = swap_low_bytes(subst_word(x, 1'b0)) ^ k2;
    return x;
  endfunction

  function automatic logic [31:0] decrypt_block(input logic [31:0] x);
    logic [31:0] k1;
    logic [31:0] k2;
    k1 = mirror_key(cfg_key);
    k2 = cfg_key ^ k1;
    x = subst_word(swap_low_bytes(x ^ k2), 1'b1);
    x = subst_word(swap_low_bytes(x ^ k1), 1'b1);
    return x ^ cfg_key;
  endfunction

  function automatic logic [31:0] cipher_step(input logic [31:0] d, input logic fb);
    logic [31:0] c;
    logic [31:0] res;
    c = fb ? cfg_iv : chain_reg;
    if (cfg_mode == MODE_OFB) begin
      chain_reg = encrypt_block(c);
      res = chain_reg ^ d;
    end else if (cfg_dir == DIR_ENC) begin
      res = encrypt_block((cfg_mode == MODE_CBC) ? (d ^ c) : d);
      chain_reg = res;
    end else begin
      res = decrypt_block(d);
      if (cfg_mode == MODE_CBC) begin
        res = res ^ c;
      end
      chain_reg = d;
    end
    return res;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrW'({idx, 2'b00});
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_KEY:  cfg_key = val;
      REG_IV:   cfg_iv = val;
      REG_MODE: cfg_mode = val[1:0];
      REG_DIR:  cfg_dir = val[0];
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_block(input logic [31:0] d, input logic fb);
    while (!quiet && $urandom_range(99) < 20) begin
      in_valid_i <= 1'b0;
      data_in_i <= $urandom;
      first_block_i <= 1'($urandom_range(1));
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_in_i <= d;
    first_block_i <= fb;
    do @(posedge clk_i); while (!in_ready_o);
    blocks_due.push_back(cipher_step(d, fb));
    @(negedge clk_i);
  endtask

  // drop valid, wait for every transaction to come back, then let the pipeline empty
  task automatic settle();
    in_valid_i <= 1'b0;
    while (blocks_due.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic configure_random();
    logic [31:0] k;
    case ($urandom_range(7))
      0: k = 32'h0000_0000;
      1: k = 32'hffff_ffff;
      2: k = 32'h0000_0001;
      3: k = 32'h8000_0000;
      default: k = $urandom;
    endcase
    reg_write(REG_KEY, k);
    reg_write(REG_IV, rand_word());
    reg_write(REG_MODE, {30'd0, 2'($urandom_range(3))});
    reg_write(REG_DIR, {31'd0, 1'($urandom_range(1))});
  endtask

  task automatic send_messages(input int count);
    int sent;
    int len;
    logic fb;
    sent = 0;
    while (sent < count) begin
      len = $urandom_range(1, 12);
      for (int j = 0; j < len && sent < count; j++) begin
        fb = (j == 0);
        if ($urandom_range(9) == 0) begin
          fb = ~fb;
        end
        send_block(rand_word(), fb);
        sent++;
      end
    end
  endtask

  task automatic test_defaults();
    send_block(32'h0000_0000, 1'b0);
    send_block(32'hffff_ffff, 1'b1);
    send_block(32'h7373_7373, 1'b0);
    settle();
  endtask

  task automatic test_ecb();
    reg_write(REG_KEY, 32'hffff_ffff);
    send_block(32'h0000_0000, 1'b0);
    send_block(32'hffff_ffff, 1'b0);
    settle();
    reg_write(REG_DIR, {31'd0, DIR_DEC});
    reg_write(REG_KEY, 32'h8000_0000);
    send_block(32'h0000_0000, 1'b1);
    send_block(32'hffff_ffff, 1'b0);
    settle();
  endtask

  task automatic test_cbc();
    reg_write(REG_MODE, {30'd0, MODE_CBC});
    reg_write(REG_DIR, {31'd0, DIR_ENC});
    reg_write(REG_IV, 32'hffff_ffff);
    reg_write(REG_KEY, 32'h1357_9bdf);
    send_block(32'ha5a5_a5a5, 1'b1);
    send_block(32'h5a5a_5a5a, 1'b0);
    send_block(32'h0000_0000, 1'b0);
    settle();
    reg_write(REG_DIR, {31'd0, DIR_DEC});
    reg_write(REG_IV, 32'h0000_0000);
    send_block(32'hffff_ffff, 1'b1);
    send_block(32'h1234_5678, 1'b0);
    settle();
  endtask

  task automatic test_ofb();
    reg_write(REG_MODE, {30'd0, MODE_OFB});
    reg_write(REG_KEY, 32'h0000_0001);
    reg_write(REG_IV, 32'h8000_0000);
    reg_write(REG_DIR, {31'd0, DIR_ENC});
    send_block(32'h0000_0000, 1'b1);
    send_block(32'hffff_ffff, 1'b0);
    settle();
    reg_write(REG_DIR, {31'd0, DIR_DEC});
    send_block(32'h0000_0000, 1'b0);
    send_block(32'hc3c3_c3c3, 1'b1);
    settle();
  endtask

  task automatic test_mode_three();
    reg_write(REG_MODE, {30'd0, MODE_RSVD});
    reg_write(REG_DIR, {31'd0, DIR_ENC});
    send_block(32'h0000_0001, 1'b1);
    settle();
    reg_write(REG_DIR, {31'd0, DIR_DEC});
    send_block(32'hffff_fffe, 1'b0);
    settle();
  endtask

  // ECB still advances the chain; CBC must pick it up afterwards
  task automatic test_ecb_chain_carry();
    reg_write(REG_MODE, {30'd0, MODE_ECB});
    reg_write(REG_DIR, {31'd0, DIR_ENC});
    send_block(32'hdead_beef, 1'b0);
    send_block(32'h0123_4567, 1'b0);
    settle();
    reg_write(REG_MODE, {30'd0, MODE_CBC});
    send_block(32'h0000_0000, 1'b0);
    settle();
  endtask

  task automatic test_random_messages();
    for (int phase = 0; phase < 20; phase++) begin
      configure_random();
      send_messages(50);
      settle();
    end
  endtask

  task automatic test_back_to_back();
    quiet = 1'b1;
    configure_random();
    send_messages(100);
    settle();
    quiet = 1'b0;
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= quiet || ($urandom_range(99) >= 20);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (blocks_due.size() == 0) begin
        bad_blocks++;
        if (bad_blocks <= 10) begin
          $display("unexpected data_out transaction: %h", data_out_o);
        end
      end else if (data_out_o !== blocks_due[0]) begin
        bad_blocks++;
        if (bad_blocks <= 10) begin
          $display("data_out mismatch: expected %h, got %h", blocks_due[0], data_out_o);
        end
        void'(blocks_due.pop_front());
      end else begin
        void'(blocks_due.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[toy_spn_cipher_ecb_cbc_ofb] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    data_in_i = '0;
    first_block_i = 1'b0;
    out_ready_i = 1'b0;
    cfg_key = '0;
    cfg_iv = '0;
    cfg_mode = MODE_ECB;
    cfg_dir = DIR_ENC;
    chain_reg = '0;
    bad_blocks = 0;
    idle_cycles = 0;
    quiet = 1'b0;
    for (int i = 0; i < 256; i++) begin
      unsubst[SUBST[i]] = 8'(i);
    end
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_defaults();
    test_ecb();
    test_cbc();
    test_ofb();
    test_mode_three();
    test_ecb_chain_carry();
    test_random_messages();
    test_back_to_back();
    settle();

    if (bad_blocks == 0 && blocks_due.size() == 0) begin
      $display("[toy_spn_cipher_ecb_cbc_ofb] OK");
    end else begin
      $display("[toy_spn_cipher_ecb_cbc_ofb] ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/spn_pkg.sv
rtl/spn_regs.sv
rtl/spn_core.sv
rtl/toy_spn_cipher_ecb_cbc_ofb.sv
tb/toy_spn_cipher_ecb_cbc_ofb_tb.sv
